>>> design/gmrs_pkg.sv
// package with constants and field positions for the gps module recovery sequencer
package gmrs_pkg;

    // widths of the stored values
    localparam int unsigned NoRespWidth = 16;
    localparam int unsigned SeqWidth    = 8;
    localparam int unsigned LedWidth    = 5;
    localparam int unsigned AddrWidth   = 3;
    localparam int unsigned InWidth     = 8;
    localparam int unsigned OutWidth    = 8;

    // no-response counter ceiling
    localparam logic [NoRespWidth-1:0] NoRespMax = 16'hFFFF;

    // recovery sequence steps
    localparam logic [SeqWidth-1:0] HoldoffTicks = 8'd160;
    localparam logic [SeqWidth-1:0] StepPower    = 8'd60;
    localparam logic [SeqWidth-1:0] StepOnA      = 8'd80;
    localparam logic [SeqWidth-1:0] StepOnB      = 8'd100;
    localparam logic [SeqWidth-1:0] StepOnC      = 8'd120;
    localparam logic [SeqWidth-1:0] StepOffA     = 8'd92;
    localparam logic [SeqWidth-1:0] StepOffB     = 8'd112;
    localparam logic [SeqWidth-1:0] StepOffC     = 8'd132;
    localparam logic [SeqWidth-1:0] StepRetry    = 8'd160;

    // register reset values
    localparam logic [15:0]         TimeoutReset = 16'd200;
    localparam logic [LedWidth-1:0] LedHoldReset = 5'd30;

    // register indexes (taken from paddr[2])
    typedef enum logic {
        REG_TIMEOUT  = 1'b0,
        REG_LED_HOLD = 1'b1
    } reg_index_t;

    // input request bit positions
    localparam int unsigned InUpdateOk    = 0;
    localparam int unsigned InDataError   = 1;
    localparam int unsigned InModuleAwake = 2;
    localparam int unsigned InFixGood     = 3;
    localparam int unsigned InQcMode      = 4;

    // result bit positions
    localparam int unsigned OutAlive      = 0;
    localparam int unsigned OutResetPin   = 1;
    localparam int unsigned OutPowerEn    = 2;
    localparam int unsigned OutAntenna    = 3;
    localparam int unsigned OutOnoffPin   = 4;
    localparam int unsigned OutLedOn      = 5;
    localparam int unsigned OutRecovering = 6;

endpackage

>>> design/gps_module_recovery_sequencer.sv
// gps module recovery sequencer: tick monitor, recovery sequence and fix led
// the result of an accepted tick request is registered onto m_tdata in the next cycle
// throughput: one tick request per cycle; the output register frees s_tready
// whenever the result is taken or the output is empty
// reset (aresetn low, synchronous): counters cleared, power and antenna on,
// timeout 200 ticks, led hold 30 ticks, output empty
module gps_module_recovery_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tick request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] update_ok [1] data_error [2] module_awake [3] fix_good [4] qc_mode
    input  logic [gmrs_pkg::InWidth-1:0]   s_tdata,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] alive [1] reset_pin [2] power_enable [3] antenna_power
    // [4] onoff_pin [5] led_on [6] recovering
    output logic [gmrs_pkg::OutWidth-1:0]  m_tdata,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gmrs_pkg::AddrWidth-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import gmrs_pkg::*;

    // configuration registers
    logic [15:0]          timeout_reg;
    logic [LedWidth-1:0]  led_hold_reg;

    // sequencer state
    logic [NoRespWidth-1:0] noresp_reg, noresp_next;
    logic                   alive_next;
    logic                   dead_reg, dead_next;
    logic [SeqWidth-1:0]    seq_reg, seq_next;
    logic                   rst_lvl_reg, rst_lvl_next;
    logic                   pwr_lvl_reg, pwr_lvl_next;
    logic                   ant_lvl_reg, ant_lvl_next;
    logic                   onoff_reg, onoff_next;
    logic                   led_reg, led_next;
    logic [LedWidth-1:0]    led_cnt_reg, led_cnt_next;

    // output register
    logic                   m_tvalid_reg;
    logic [OutWidth-1:0]    m_tdata_reg, m_tdata_next;

    logic accept;
    logic upd, err, awake, fix, qc;
    logic [SeqWidth-1:0] seq_inc;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign upd   = s_tdata[InUpdateOk];
    assign err   = s_tdata[InDataError];
    assign awake = s_tdata[InModuleAwake];
    assign fix   = s_tdata[InFixGood];
    assign qc    = s_tdata[InQcMode];

    // apb port, always ready
    assign pready = 1'b1;
    always_comb begin
        unique case (reg_index_t'(paddr[2]))
            REG_TIMEOUT:  prdata = {16'd0, timeout_reg};
            REG_LED_HOLD: prdata = {{(32-LedWidth){1'b0}}, led_hold_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= TimeoutReset;
            led_hold_reg <= LedHoldReset;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_index_t'(paddr[2]))
                REG_TIMEOUT:  timeout_reg  <= pwdata[15:0];
                REG_LED_HOLD: led_hold_reg <= pwdata[LedWidth-1:0];
                default: ;
            endcase
        end
    end

    // monitor and recovery sequence
    assign seq_inc = seq_reg + 8'd1;

    always_comb begin
        noresp_next  = noresp_reg;
        dead_next    = dead_reg;
        seq_next     = seq_reg;
        rst_lvl_next = rst_lvl_reg;
        pwr_lvl_next = pwr_lvl_reg;
        ant_lvl_next = ant_lvl_reg;
        onoff_next   = onoff_reg;

        // saturating no-response counter
        if (upd) begin
            noresp_next = '0;
        end else if (noresp_reg != NoRespMax) begin
            noresp_next = noresp_reg + 16'd1;
        end
        alive_next = (noresp_next < timeout_reg);

        if (!dead_reg) begin
            // hold-off countdown, then check health
            if (seq_reg != '0) begin
                seq_next = seq_reg - 8'd1;
            end else if (err || !awake) begin
                rst_lvl_next = 1'b1;
                pwr_lvl_next = 1'b0;
                ant_lvl_next = 1'b0;
                dead_next    = 1'b1;
            end
        end else if (awake) begin
            // early wake leaves recovery with a hold-off
            dead_next = 1'b0;
            seq_next  = HoldoffTicks;
        end else begin
            seq_next = seq_inc;
            case (seq_inc)
                StepPower: begin
                    rst_lvl_next = 1'b0;
                    pwr_lvl_next = 1'b1;
                    ant_lvl_next = 1'b1;
                    onoff_next   = 1'b0;
                end
                StepOnA, StepOnB, StepOnC: begin
                    onoff_next = 1'b1;
                end
                StepOffA, StepOffB, StepOffC: begin
                    onoff_next = 1'b0;
                end
                StepRetry: begin
                    dead_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // fix led with minimum hold, frozen in qc mode
    always_comb begin
        led_next     = led_reg;
        led_cnt_next = led_cnt_reg;
        if (!qc) begin
            if (led_cnt_reg >= led_hold_reg) begin
                led_cnt_next = led_hold_reg;
            end else begin
                led_cnt_next = led_cnt_reg + 5'd1;
            end
            if (alive_next && fix && !led_reg && (led_cnt_next >= led_hold_reg)) begin
                led_next     = 1'b1;
                led_cnt_next = '0;
            end
            if (led_next && (led_cnt_next >= led_hold_reg)) begin
                led_next     = 1'b0;
                led_cnt_next = '0;
            end
        end
    end

    // state update on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noresp_reg  <= '0;
            dead_reg    <= 1'b0;
            seq_reg     <= '0;
            rst_lvl_reg <= 1'b0;
            pwr_lvl_reg <= 1'b1;
            ant_lvl_reg <= 1'b1;
            onoff_reg   <= 1'b0;
            led_reg     <= 1'b0;
            led_cnt_reg <= '0;
        end else if (accept) begin
            noresp_reg  <= noresp_next;
            dead_reg    <= dead_next;
            seq_reg     <= seq_next;
            rst_lvl_reg <= rst_lvl_next;
            pwr_lvl_reg <= pwr_lvl_next;
            ant_lvl_reg <= ant_lvl_next;
            onoff_reg   <= onoff_next;
            led_reg     <= led_next;
            led_cnt_reg <= led_cnt_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result fields packed into the output word
    always_comb begin
        m_tdata_next                = '0;
        m_tdata_next[OutAlive]      = alive_next;
        m_tdata_next[OutResetPin]   = rst_lvl_next;
        m_tdata_next[OutPowerEn]    = pwr_lvl_next;
        m_tdata_next[OutAntenna]    = ant_lvl_next;
        m_tdata_next[OutOnoffPin]   = onoff_next;
        m_tdata_next[OutLedOn]      = led_next;
        m_tdata_next[OutRecovering] = dead_next;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

>>> tb/gps_module_recovery_sequencer_tb.sv
// testbench for the gps module recovery sequencer: tick requests checked against a local model
module gps_module_recovery_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gmrs_pkg::*;

    localparam int unsigned StallLimit = 1000;
    localparam int unsigned HoldCycles = 80;
    localparam int unsigned ReportMax  = 10;

    // one tick request, update_ok in the lowest bit
    typedef struct packed {
        logic qc_mode;
        logic fix_good;
        logic module_awake;
        logic data_error;
        logic update_ok;
    } tick_t;

    // one status result, alive in the lowest bit
    typedef struct packed {
        logic recovering;
        logic led_on;
        logic onoff_pin;
        logic antenna_power;
        logic power_enable;
        logic reset_pin;
        logic alive;
    } status_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [InWidth-1:0]   s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutWidth-1:0]  m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [AddrWidth-1:0] paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // model of the block: register copies and state
    logic [15:0]            cfg_timeout  = TimeoutReset;
    logic [LedWidth-1:0]    cfg_led_hold = LedHoldReset;
    logic [NoRespWidth-1:0] miss_count   = '0;
    logic [SeqWidth-1:0]    step_count   = '0;
    logic [LedWidth-1:0]    led_timer    = '0;
    logic                   alive_q      = 1'b0;
    logic                   recovering_q = 1'b0;
    logic                   rst_pin_q    = 1'b0;
    logic                   power_q      = 1'b1;
    logic                   antenna_q    = 1'b1;
    logic                   onoff_q      = 1'b0;
    logic                   led_q        = 1'b0;

    status_t status_due [$];
    string   field_names [7] = '{"alive", "reset_pin", "power_enable", "antenna_power",
                                 "onoff_pin", "led_on", "recovering"};

    int          mismatches         = 0;
    int          ticks_sent         = 0;
    int          results_checked    = 0;
    int          settings_used      = 0;
    int          recoveries_started = 0;
    int          full_sequences     = 0;
    int          early_wakes        = 0;
    int          send_idle_pct      = 0;
    int          stall_pct          = 0;
    logic        long_hold          = 1'b0;
    int unsigned hold_count         = 0;

    gps_module_recovery_sequencer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // status after one tick, advancing the model state
    function automatic status_t predict_status(input tick_t t);
        status_t s;
        // no-response counter and alive flag
        if (t.update_ok) begin
            miss_count = '0;
        end else if (miss_count != NoRespMax) begin
            miss_count = miss_count + 16'd1;
        end
        alive_q = (miss_count < cfg_timeout);

        // hold-off countdown while healthy, step counter while recovering
        if (!recovering_q) begin
            if (step_count != '0) begin
                step_count = step_count - 8'd1;
            end else if (t.data_error || !t.module_awake) begin
                rst_pin_q    = 1'b1;
                power_q      = 1'b0;
                antenna_q    = 1'b0;
                recovering_q = 1'b1;
                recoveries_started++;
            end
        end else begin
            step_count = step_count + 8'd1;
            if (t.module_awake) begin
                // early wake: leave at once, pins untouched
                recovering_q = 1'b0;
                step_count   = HoldoffTicks;
                early_wakes++;
            end else begin
                case (step_count)
                    StepPower: begin
                        rst_pin_q = 1'b0;
                        power_q   = 1'b1;
                        antenna_q = 1'b1;
                        onoff_q   = 1'b0;
                    end
                    StepOnA, StepOnB, StepOnC: begin
                        onoff_q = 1'b1;
                    end
                    StepOffA, StepOffB, StepOffC: begin
                        onoff_q = 1'b0;
                    end
                    StepRetry: begin
                        recovering_q = 1'b0;
                        full_sequences++;
                    end
                    default: begin
                    end
                endcase
            end
        end

        // fix led with minimum hold, frozen in qc mode
        if (!t.qc_mode) begin
            if (led_timer >= cfg_led_hold) begin
                led_timer = cfg_led_hold;
            end else begin
                led_timer = led_timer + 5'd1;
            end
            if (alive_q && t.fix_good && !led_q && led_timer >= cfg_led_hold) begin
                led_q     = 1'b1;
                led_timer = '0;
            end
            if (led_q && led_timer >= cfg_led_hold) begin
                led_q     = 1'b0;
                led_timer = '0;
            end
        end

        s.alive         = alive_q;
        s.reset_pin     = rst_pin_q;
        s.power_enable  = power_q;
        s.antenna_power = antenna_q;
        s.onoff_pin     = onoff_q;
        s.led_on        = led_q;
        s.recovering    = recovering_q;
        return s;
    endfunction

    function automatic tick_t mk_tick(input logic upd, input logic err, input logic awake,
                                      input logic fix, input logic qc);
        tick_t t;
        t.update_ok    = upd;
        t.data_error   = err;
        t.module_awake = awake;
        t.fix_good     = fix;
        t.qc_mode      = qc;
        return t;
    endfunction

    // random tick shaped by the model state so that recoveries mostly run to the end
    function automatic tick_t random_tick();
        tick_t t;
        t.update_ok = ($urandom_range(99) < 75);
        t.fix_good  = 1'($urandom_range(1));
        t.qc_mode   = ($urandom_range(99) < 10);
        if (recovering_q) begin
            t.module_awake = ($urandom_range(999) < 3);
            t.data_error   = 1'($urandom_range(1));
        end else if (step_count != '0) begin
            t.module_awake = 1'($urandom_range(1));
            t.data_error   = 1'($urandom_range(1));
        end else begin
            t.module_awake = ($urandom_range(99) < 85);
            t.data_error   = ($urandom_range(99) < 10);
        end
        return t;
    endfunction

    // offer one tick request, with random gaps before it
    task automatic send_tick(input tick_t t);
        logic [InWidth-1:0] packed_req;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        packed_req                = '0;
        packed_req[InUpdateOk]    = t.update_ok;
        packed_req[InDataError]   = t.data_error;
        packed_req[InModuleAwake] = t.module_awake;
        packed_req[InFixGood]     = t.fix_good;
        packed_req[InQcMode]      = t.qc_mode;
        s_tvalid <= 1'b1;
        s_tdata  <= packed_req;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        status_due.push_back(predict_status(t));
        ticks_sent++;
    endtask

    // stop offering and wait for every expected status
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (status_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // one apb transfer, setup then access
    task automatic reg_access(input reg_index_t idx, input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_register(input reg_index_t idx);
        logic [31:0] want;
        logic [31:0] got;
        want = (idx == REG_TIMEOUT) ? {16'd0, cfg_timeout}
                                    : {{(32-LedWidth){1'b0}}, cfg_led_hold};
        reg_access(idx, 1'b0, 32'd0, got);
        if (got !== want) begin
            if (mismatches < ReportMax) begin
                $display("register %s read: expected %0d, got %0d", idx.name(), want, got);
            end
            mismatches++;
        end
    endtask

    task automatic set_register(input reg_index_t idx, input logic [31:0] value);
        logic [31:0] ignored;
        drain_results();
        reg_access(idx, 1'b1, value, ignored);
        if (idx == REG_TIMEOUT) begin
            cfg_timeout = value[15:0];
        end else begin
            cfg_led_hold = value[LedWidth-1:0];
        end
        settings_used++;
        check_register(idx);
    endtask

    // compare each status with the oldest expectation
    always @(posedge aclk) begin
        status_t want;
        status_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.alive         = m_tdata[OutAlive];
            got.reset_pin     = m_tdata[OutResetPin];
            got.power_enable  = m_tdata[OutPowerEn];
            got.antenna_power = m_tdata[OutAntenna];
            got.onoff_pin     = m_tdata[OutOnoffPin];
            got.led_on        = m_tdata[OutLedOn];
            got.recovering    = m_tdata[OutRecovering];
            if (status_due.size() == 0) begin
                if (mismatches < ReportMax) begin
                    $display("status %b arrived with nothing expected at %0t", m_tdata, $time);
                end
                mismatches++;
            end else begin
                want = status_due.pop_front();
                results_checked++;
                for (int i = 0; i < 7; i++) begin
                    if (want[i] !== got[i]) begin
                        if (mismatches < ReportMax) begin
                            $display("status %0d field %s: expected %b, got %b",
                                     results_checked, field_names[i], want[i], got[i]);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    // result side: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin
        if (long_hold && hold_count < HoldCycles) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            if (!long_hold) begin
                hold_count <= 0;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles without any accepted request, status or register access
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < StallLimit) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: nothing accepted for %0d cycles", StallLimit);
        $display("gps_module_recovery_sequencer_tb: FAIL");
        $finish;
    end

    task automatic test_register_defaults();
        check_register(REG_TIMEOUT);
        check_register(REG_LED_HOLD);
    endtask

    // led toggling, qc freeze, timeout, recovery entry, early wake, zero settings
    task automatic test_directed_ticks();
        set_register(REG_TIMEOUT, 32'd3);
        set_register(REG_LED_HOLD, 32'd2);
        repeat (4) send_tick(mk_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        repeat (2) send_tick(mk_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
        repeat (4) send_tick(mk_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        repeat (3) send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        repeat (2) send_tick(mk_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
        // zero timeout and zero led hold
        set_register(REG_TIMEOUT, 32'd0);
        set_register(REG_LED_HOLD, 32'd0);
        repeat (3) send_tick(mk_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        set_register(REG_TIMEOUT, 32'd65535);
        set_register(REG_LED_HOLD, 32'd31);
        repeat (2) send_tick(mk_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
    endtask

    // random ticks under four idling patterns and register settings
    task automatic test_idle_phases();
        int idle_pcts [4]  = '{0, 46, 0, 35};
        int stall_pcts [4] = '{0, 0, 46, 35};
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    set_register(REG_TIMEOUT, 32'd1);
                    set_register(REG_LED_HOLD, 32'd1);
                end
                1: begin
                    set_register(REG_TIMEOUT, 32'd5);
                    set_register(REG_LED_HOLD, 32'd31);
                end
                2: begin
                    set_register(REG_TIMEOUT, 32'd65535);
                    set_register(REG_LED_HOLD, 32'd3);
                end
                default: begin
                    set_register(REG_TIMEOUT, $urandom_range(12, 2));
                    set_register(REG_LED_HOLD, $urandom_range(8, 1));
                end
            endcase
            send_idle_pct = idle_pcts[p];
            stall_pct <= stall_pcts[p];
            repeat (90) send_tick(random_tick());
        end
        drain_results();
    endtask

    // result side held off while requests keep coming
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct <= 20;
        long_hold <= 1'b1;
        repeat (40) send_tick(random_tick());
        long_hold <= 1'b0;
        drain_results();
    endtask

    // long run without updates against the largest timeout and led hold
    task automatic test_noresp_run();
        tick_t t;
        set_register(REG_TIMEOUT, 32'hFFFF_FFFF);
        set_register(REG_LED_HOLD, 32'hFFFF_FFFF);
        send_idle_pct = 0;
        stall_pct <= 0;
        repeat (30) begin
            t = random_tick();
            t.update_ok = 1'b0;
            send_tick(t);
        end
        repeat (6) send_tick(random_tick());
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_defaults();
        test_directed_ticks();
        test_idle_phases();
        test_output_backpressure();
        test_noresp_run();
        drain_results();
        repeat (8) @(posedge aclk);
        $display("%0d tick requests over %0d register settings, %0d statuses checked",
                 ticks_sent, settings_used, results_checked);
        $display("recovery entered %0d times: %0d reached the retry step, %0d left on wake",
                 recoveries_started, full_sequences, early_wakes);
        if (mismatches == 0) begin
            $display("gps_module_recovery_sequencer_tb: PASS");
        end else begin
            $display("gps_module_recovery_sequencer_tb: FAIL");
        end
        $finish;
    end

endmodule
